// ----- sv/bdrf_pkg.sv -----
// Shared constants and types for the bypass delay with reload fade block.
// No dependencies; every other file of the block imports this package.
package bdrf_pkg;

    // Sample, delay and fade sizes (DELAY_DEPTH and FADE_LENGTH are powers of two)
    localparam int SAMPLE_W    = 24;
    localparam int DELAY_DEPTH = 4096;
    localparam int FADE_LENGTH = 128;

    localparam int ADDR_W     = $clog2(DELAY_DEPTH);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int FADE_W     = $clog2(FADE_LENGTH + 1);
    localparam int FADE_SHIFT = $clog2(FADE_LENGTH);
    localparam int PROD_W     = SAMPLE_W + FADE_W + 1;

    // Configuration port
    localparam int LAT_W       = 13;
    localparam int HOLD_EXTRA_W = 16;
    localparam int HOLD_CNT_W  = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LATENCY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_EXTRA = CFG_IDX_W'(1);

    // Stream widths
    localparam int IN_DATA_W  = 4 * SAMPLE_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;
    localparam int OUT_USER_W = 1;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int MAX_IN_FLIGHT = 3;

    // Delay memory access shared by both lanes
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wr_en;
        logic              rd_valid;
    } t_mem_ctl;

    // One result beat
    typedef struct packed {
        logic                pulse;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } t_beat;

endpackage

// ----- sv/bypass_delay_with_reload_fade.sv -----
// Top level of the bypass delay with reload fade: stream ports, control,
// two channel lanes and the merge queue. Depends on bdrf_pkg and submodules.
//
//  channel   | direction | beat contents
//  s_axis    | in        | dry L/R, wet L/R, bypass, reload level (one frame)
//  m_axis    | out       | faded L/R, reload pulse (one frame)
//  cfg       | in        | register index and write data, no read-back
//
// One frame per cycle sustained while the output queue has room; a frame
// is captured by the registered delay memory read, passes the gain multiply
// and is written into the output queue. The queue holds up to three frames;
// tready drops while three frames sit between the ports. Reset is synchronous;
// no clearing pass is run, a fill count makes unwritten delay entries read zero.
module bypass_delay_with_reload_fade (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // dry_left, dry_right, wet_left, wet_right
    input  logic [bdrf_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // bypass, reload_level
    input  logic [bdrf_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_left, out_right
    output logic [bdrf_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // reload_pulse
    output logic [bdrf_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    input  logic                              i_cfg_wen,
    input  logic [bdrf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bdrf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import bdrf_pkg::*;

    logic                accept;
    t_mem_ctl            mem_ctl;
    logic [FADE_W-1:0]   gain;
    logic                pulse;
    logic                room;
    logic [SAMPLE_W-1:0] left_out;
    logic [SAMPLE_W-1:0] right_out;
    t_beat               beat;

    logic                r_s1_valid;
    logic [FADE_W-1:0]   r_s1_gain;
    logic                r_s1_pulse;

    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    bdrf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_reload_level (i_s_axis_tuser[1]),
        .o_mem          (mem_ctl),
        .o_gain         (gain),
        .o_pulse        (pulse)
    );

    bdrf_lane u_lane_left (
        .i_clk    (i_clk),
        .i_accept (accept),
        .i_mem    (mem_ctl),
        .i_bypass (i_s_axis_tuser[0]),
        .i_dry    (i_s_axis_tdata[0*SAMPLE_W +: SAMPLE_W]),
        .i_wet    (i_s_axis_tdata[2*SAMPLE_W +: SAMPLE_W]),
        .i_gain   (r_s1_gain),
        .o_sample (left_out)
    );

    bdrf_lane u_lane_right (
        .i_clk    (i_clk),
        .i_accept (accept),
        .i_mem    (mem_ctl),
        .i_bypass (i_s_axis_tuser[0]),
        .i_dry    (i_s_axis_tdata[1*SAMPLE_W +: SAMPLE_W]),
        .i_wet    (i_s_axis_tdata[3*SAMPLE_W +: SAMPLE_W]),
        .i_gain   (r_s1_gain),
        .o_sample (right_out)
    );

    // Carry gain and pulse alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_gain  <= gain;
            r_s1_pulse <= pulse;
        end
    end

    bdrf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_left  (left_out),
        .i_right (right_out),
        .i_pulse (r_s1_pulse),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_beat  (beat)
    );

    assign o_m_axis_tdata = {beat.right, beat.left};
    assign o_m_axis_tuser = beat.pulse;

endmodule

// ----- sv/bdrf_ctrl.sv -----
// Control for the bypass delay: config registers, ring position, fill count
// and the reload fade sequencer. Depends on bdrf_pkg.
module bdrf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [bdrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdrf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                          i_accept,
    input  logic                          i_reload_level,
    output bdrf_pkg::t_mem_ctl            o_mem,
    output logic [bdrf_pkg::FADE_W-1:0]   o_gain,
    output logic                          o_pulse
);
    import bdrf_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_OUT  = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;
    localparam logic [1:0] PH_IN   = 2'd3;

    localparam logic [FADE_W-1:0] FADE_FULL = FADE_W'(FADE_LENGTH);

    logic [LAT_W-1:0]        r_latency;
    logic [HOLD_EXTRA_W-1:0] r_hold_extra;
    logic [ADDR_W-1:0]       r_pos,   n_pos;
    logic [LEN_W-1:0]        r_fill,  n_fill;
    logic [1:0]              r_phase, n_phase;
    logic [FADE_W-1:0]       r_fade,  n_fade;
    logic [HOLD_CNT_W-1:0]   r_hold,  n_hold;
    logic                    r_seen;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  pos_inc;
    logic              use_delay;
    logic              start;
    logic [1:0]        phase0;
    logic [FADE_W-1:0] fade0;
    logic [FADE_W-1:0] fade1;
    logic [HOLD_CNT_W-1:0] hold1;

    // Delay length is the latency limited to the memory depth
    always_comb begin
        if (int'(r_latency) >= DELAY_DEPTH) begin
            len = LEN_W'(DELAY_DEPTH);
        end else begin
            len = LEN_W'(r_latency);
        end
        use_delay = (len != '0);
        pos_ext   = {1'b0, r_pos};
        pos_inc   = pos_ext + LEN_W'(1);
        n_pos     = (pos_inc >= len) ? '0 : pos_inc[ADDR_W-1:0];
        // entries at or past the fill count were never written and read as zero
        n_fill    = (pos_ext >= r_fill) ? pos_inc : r_fill;
    end

    assign o_mem.addr     = r_pos;
    assign o_mem.wr_en    = use_delay;
    assign o_mem.rd_valid = (pos_ext < r_fill);

    always_comb begin
        start  = i_reload_level && !r_seen && (r_phase == PH_IDLE);
        phase0 = start ? PH_OUT : r_phase;
        fade0  = start ? FADE_FULL : r_fade;
        fade1  = (fade0 != '0) ? fade0 - FADE_W'(1) : '0;
        hold1  = (r_hold != '0) ? r_hold - HOLD_CNT_W'(1) : '0;
        n_phase = phase0;
        n_fade  = r_fade;
        n_hold  = r_hold;
        o_gain  = FADE_FULL;
        o_pulse = 1'b0;
        unique case (phase0)
            PH_OUT: begin
                o_gain = fade0;
                n_fade = fade1;
                if (fade1 == '0) begin
                    o_pulse = 1'b1;
                    n_phase = PH_HOLD;
                    n_hold  = HOLD_CNT_W'(r_latency) + HOLD_CNT_W'(r_hold_extra);
                end
            end
            PH_HOLD: begin
                o_gain = '0;
                n_hold = hold1;
                if (hold1 == '0) begin
                    n_phase = PH_IN;
                    n_fade  = FADE_FULL;
                end
            end
            PH_IN: begin
                o_gain = (fade0 <= FADE_FULL) ? FADE_FULL - fade0 : '0;
                n_fade = fade1;
                if (fade1 == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_fade = fade0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latency    <= '0;
            r_hold_extra <= '0;
        end else if (i_cfg_wen) begin
            if (i_cfg_idx == REG_LATENCY) begin
                r_latency <= i_cfg_wdata[LAT_W-1:0];
            end
            if (i_cfg_idx == REG_HOLD_EXTRA) begin
                r_hold_extra <= i_cfg_wdata[HOLD_EXTRA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_phase <= PH_IDLE;
            r_fade  <= '0;
            r_hold  <= '0;
            r_seen  <= 1'b0;
        end else if (i_accept) begin
            r_seen  <= i_reload_level;
            r_phase <= n_phase;
            r_fade  <= n_fade;
            r_hold  <= n_hold;
            if (use_delay) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
            end
        end
    end

endmodule

// ----- sv/bdrf_lane.sv -----
// One channel lane: delay memory, dry/wet selection and fade gain scaling.
// Depends on bdrf_pkg; two copies run side by side for left and right.
module bdrf_lane (
    input  logic                           i_clk,
    input  logic                           i_accept,
    input  bdrf_pkg::t_mem_ctl             i_mem,
    input  logic                           i_bypass,
    input  logic [bdrf_pkg::SAMPLE_W-1:0]  i_dry,
    input  logic [bdrf_pkg::SAMPLE_W-1:0]  i_wet,
    input  logic [bdrf_pkg::FADE_W-1:0]    i_gain,
    output logic [bdrf_pkg::SAMPLE_W-1:0]  o_sample
);
    import bdrf_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] r_rd;
    logic [SAMPLE_W-1:0] r_direct;
    logic                r_take_mem;
    logic                r_rd_ok;

    logic signed [SAMPLE_W-1:0] sample;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   biased;

    // Read the old entry before this beat overwrites it
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd <= r_mem[i_mem.addr];
            if (i_mem.wr_en) begin
                r_mem[i_mem.addr] <= i_dry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_direct   <= i_bypass ? i_dry : i_wet;
            r_take_mem <= i_bypass && i_mem.wr_en;
            r_rd_ok    <= i_mem.rd_valid;
        end
    end

    // Round half up: floor((s * g + F/2) / F)
    always_comb begin
        if (r_take_mem) begin
            sample = r_rd_ok ? $signed(r_rd) : '0;
        end else begin
            sample = $signed(r_direct);
        end
        prod     = sample * $signed({1'b0, i_gain});
        biased   = prod + PROD_W'(FADE_LENGTH / 2);
        o_sample = biased[FADE_SHIFT +: SAMPLE_W];
    end

endmodule

// ----- sv/bdrf_merge.sv -----
// Merge stage: joins both lane results and the reload pulse into one beat
// and queues beats towards the output stream. Depends on bdrf_pkg.
module bdrf_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [bdrf_pkg::SAMPLE_W-1:0]    i_left,
    input  logic [bdrf_pkg::SAMPLE_W-1:0]    i_right,
    input  logic                             i_pulse,
    output logic                             o_room,
    output logic                             o_valid,
    input  logic                             i_ready,
    output bdrf_pkg::t_beat                  o_beat
);
    import bdrf_pkg::*;

    t_beat              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_beat  = r_queue[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // Count the beat still in the lanes so the queue never overflows
    assign o_room  = (r_count + QCNT_W'(i_push)) < QCNT_W'(MAX_IN_FLIGHT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_queue[r_wr_ptr] <= '{pulse: i_pulse, right: i_right, left: i_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop);
        end
    end

endmodule

// ----- sv/bdrf_chk.sv -----
// Port-level checker for the bypass delay with reload fade, bound to the
// top level. Depends on bdrf_pkg.
module bdrf_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [bdrf_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic [bdrf_pkg::OUT_USER_W-1:0]   o_m_axis_tuser
);
    import bdrf_pkg::*;

    logic              in_beat;
    logic              out_beat;
    logic [QCNT_W:0]   r_pending;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat = o_m_axis_tvalid && i_m_axis_tready;

    // Frames taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + (QCNT_W+1)'(in_beat) - (QCNT_W+1)'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (r_pending != '0))
        else $error("output beat with no frame outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= (QCNT_W+1)'(MAX_IN_FLIGHT))
        else $error("more frames in flight than the queue allows");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> o_s_axis_tready)
        else $error("input stalled with nothing outstanding");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind bypass_delay_with_reload_fade bdrf_chk u_bdrf_chk (.*);

// ----- verif/bypass_delay_with_reload_fade_test.sv -----
`timescale 1ns / 100ps
// Stream-level test of bypass_delay_with_reload_fade: drives frames and register writes,
// predicts each faded frame and checks it beat by beat. Depends on bdrf_pkg and the RTL.
module bypass_delay_with_reload_fade_test;
    import bdrf_pkg::*;

    typedef enum logic [1:0] {FADE_IDLE, FADE_OUT, FADE_HOLD, FADE_IN} t_fade_phase;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct {
        logic signed [SAMPLE_W-1:0] dry_l;
        logic signed [SAMPLE_W-1:0] dry_r;
        logic signed [SAMPLE_W-1:0] wet_l;
        logic signed [SAMPLE_W-1:0] wet_r;
        logic                       bypass;
        logic                       reload;
    } t_frame;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // dry_left, dry_right, wet_left, wet_right
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    // bypass, reload_level
    logic [IN_USER_W-1:0]  i_s_axis_tuser  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // out_left, out_right
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // reload_pulse
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  i_cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;

    bypass_delay_with_reload_fade uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state and register copies
    logic signed [SAMPLE_W-1:0] dly_l [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] dly_r [DELAY_DEPTH];
    int unsigned                dly_pos;
    t_fade_phase                phase;
    int unsigned                fade_cnt;
    int unsigned                hold_cnt;
    logic                       level_prev;
    int unsigned                cfg_latency;
    int unsigned                cfg_hold;

    t_beat       faded_frames [$];
    int unsigned error_count;
    int unsigned beats_checked;
    int unsigned frames_sent;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          reload_lvl;

    function automatic logic [SAMPLE_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] s,
                                                       int unsigned g);
        longint p;
        p = longint'(s) * longint'(g);
        // round half up: floor((2p + L) / 2L)
        return SAMPLE_W'((2 * p + FADE_LENGTH) >>> (FADE_SHIFT + 1));
    endfunction

    function automatic t_beat bypass_and_fade(t_frame f);
        int unsigned                dly_len;
        int unsigned                rd;
        int unsigned                gain;
        logic signed [SAMPLE_W-1:0] sel_l;
        logic signed [SAMPLE_W-1:0] sel_r;
        t_beat                      res;
        dly_len   = (cfg_latency < DELAY_DEPTH) ? cfg_latency : DELAY_DEPTH;
        sel_l     = f.dry_l;
        sel_r     = f.dry_r;
        gain      = FADE_LENGTH;
        res.pulse = 1'b0;
        if (f.reload && !level_prev && phase == FADE_IDLE) begin
            phase    = FADE_OUT;
            fade_cnt = FADE_LENGTH;
        end
        level_prev = f.reload;
        if (dly_len != 0) begin
            rd        = (dly_pos < DELAY_DEPTH) ? dly_pos : 0;
            sel_l     = dly_l[rd];
            sel_r     = dly_r[rd];
            dly_l[rd] = f.dry_l;
            dly_r[rd] = f.dry_r;
            dly_pos   = (rd + 1 >= dly_len) ? 0 : rd + 1;
        end
        if (!f.bypass) begin
            sel_l = f.wet_l;
            sel_r = f.wet_r;
        end
        case (phase)
            FADE_OUT: begin
                gain = fade_cnt;
                if (fade_cnt > 0) fade_cnt--;
                if (fade_cnt == 0) begin
                    res.pulse = 1'b1;
                    phase     = FADE_HOLD;
                    hold_cnt  = cfg_latency + cfg_hold;
                end
            end
            FADE_HOLD: begin
                gain = 0;
                if (hold_cnt > 0) hold_cnt--;
                if (hold_cnt == 0) begin
                    phase    = FADE_IN;
                    fade_cnt = FADE_LENGTH;
                end
            end
            FADE_IN: begin
                gain = (fade_cnt <= FADE_LENGTH) ? FADE_LENGTH - fade_cnt : 0;
                if (fade_cnt > 0) fade_cnt--;
                if (fade_cnt == 0) phase = FADE_IDLE;
            end
            default: gain = FADE_LENGTH;
        endcase
        res.left  = apply_gain(sel_l, gain);
        res.right = apply_gain(sel_r, gain);
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] corner_sample(int unsigned k);
        case (k)
            0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return SAMPLE_W'(1);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(7) == 0) return corner_sample($urandom_range(4));
        return SAMPLE_W'($urandom);
    endfunction

    function automatic t_frame make_frame(bit byp, bit lvl);
        t_frame f;
        f.dry_l  = pick_sample();
        f.dry_r  = pick_sample();
        f.wet_l  = pick_sample();
        f.wet_r  = pick_sample();
        f.bypass = byp;
        f.reload = lvl;
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                   logic [SAMPLE_W-1:0] exp);
        if (error_count < 40)
            $display("beat %0d: %s: got %h, expected %h", beats_checked, what, got, exp);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_output
        t_beat got;
        t_beat exp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.left  = o_m_axis_tdata[SAMPLE_W-1:0];
            got.right = o_m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            got.pulse = o_m_axis_tuser[0];
            if (faded_frames.size() == 0) begin
                report_mismatch("beat with nothing expected", got.left, '0);
            end else begin
                exp = faded_frames.pop_front();
                if (got.left !== exp.left)   report_mismatch("out_left", got.left, exp.left);
                if (got.right !== exp.right) report_mismatch("out_right", got.right, exp.right);
                if (got.pulse !== exp.pulse)
                    report_mismatch("reload_pulse", SAMPLE_W'(got.pulse), SAMPLE_W'(exp.pulse));
            end
            beats_checked++;
        end
    end

    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {f.wet_r, f.wet_l, f.dry_r, f.dry_l};
        i_s_axis_tuser  <= {f.reload, f.bypass};
        do @(posedge i_clk); while (!o_s_axis_tready);
        faded_frames.push_back(bypass_and_fade(f));
        frames_sent++;
    endtask

    // Drop valid and wait for every outstanding beat
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (faded_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_LATENCY:    cfg_latency = val[LAT_W-1:0];
            REG_HOLD_EXTRA: cfg_hold    = val[HOLD_EXTRA_W-1:0];
            default: ;
        endcase
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Low then high level: an edge whenever the fade is idle
    task automatic start_reload();
        send_frame(make_frame(1'($urandom_range(1)), 1'b0));
        send_frame(make_frame(1'($urandom_range(1)), 1'b1));
        reload_lvl = 1'b1;
    endtask

    // Advance frames until the fade is back to idle; level toggles are ignored meanwhile
    task automatic run_to_idle();
        while (phase != FADE_IDLE) begin
            if ($urandom_range(15) == 0) reload_lvl = !reload_lvl;
            send_frame(make_frame($urandom_range(3) != 0, reload_lvl));
        end
    endtask

    task automatic test_passthrough();
        t_frame f;
        set_idling(0, 0);
        for (int k = 0; k < 5; k++) begin
            f       = make_frame(1'b0, 1'b0);
            f.wet_l = corner_sample(k);
            f.wet_r = corner_sample(4 - k);
            send_frame(f);
            f        = make_frame(1'b1, 1'b0);
            f.dry_l  = corner_sample(k);
            f.dry_r  = corner_sample(4 - k);
            send_frame(f);
        end
        drain();
        // spare indexes must leave both registers alone
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, '1);
        repeat (4) send_frame(make_frame(1'($urandom_range(1)), 1'b0));
        drain();
    endtask

    task automatic test_short_delay();
        set_idling(15, 15);
        write_reg(REG_LATENCY, 1);
        repeat (8) send_frame(make_frame(1'($urandom_range(1)), 1'b0));
        drain();
        write_reg(REG_LATENCY, 3);
        repeat (8) send_frame(make_frame(1'($urandom_range(1)), 1'b0));
        drain();
    endtask

    task automatic test_reload_fade();
        set_idling(15, 15);
        write_reg(REG_LATENCY, 0);
        write_reg(REG_HOLD_EXTRA, 0);
        start_reload();
        // another edge during the fade out is only recorded
        send_frame(make_frame(1'b1, 1'b0));
        send_frame(make_frame(1'b1, 1'b1));
        repeat (124) send_frame(make_frame(1'($urandom_range(1)), 1'b1));
        // hold off on the last fade-out frame until everything is back
        drain();
        reload_lvl = 1'b0;
        run_to_idle();
        drain();
    endtask

    task automatic test_latency_change();
        set_idling(64, 0);
        write_reg(REG_LATENCY, 40);
        write_reg(REG_HOLD_EXTRA, 30);
        repeat (60) send_frame(make_frame($urandom_range(3) != 0, 1'b0));
        drain();
        // upper data bits fall outside the latency field
        write_reg(REG_LATENCY, 16'hE007);
        repeat (20) send_frame(make_frame($urandom_range(3) != 0, 1'b0));
        drain();
        write_reg(REG_LATENCY, 100);
        repeat (30) send_frame(make_frame($urandom_range(3) != 0, 1'b0));
        drain();
        write_reg(REG_LATENCY, 0);
        repeat (8) send_frame(make_frame(1'($urandom_range(1)), 1'b0));
        drain();
        write_reg(REG_LATENCY, 64);
        start_reload();
        repeat (140) send_frame(make_frame($urandom_range(3) != 0, reload_lvl));
        drain();
        // shorten the delay while the hold is counting down
        write_reg(REG_LATENCY, 3);
        run_to_idle();
        drain();
    endtask

    task automatic test_extremes();
        set_idling(0, 0);
        // latency beyond the ring depth, longest hold extra
        write_reg(REG_LATENCY, 16'h1FFF);
        write_reg(REG_HOLD_EXTRA, 16'hFFFF);
        repeat (60) send_frame(make_frame($urandom_range(3) != 0, 1'b0));
        drain();
        write_reg(REG_LATENCY, CFG_DATA_W'(DELAY_DEPTH));
        write_reg(REG_HOLD_EXTRA, 0);
        repeat (80) send_frame(make_frame($urandom_range(3) != 0, 1'b0));
        drain();
    endtask

    task automatic test_random();
        int unsigned start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(64, 0);
                2:       set_idling(0, 64);
                default: set_idling(15, 15);
            endcase
            case ($urandom_range(7))
                0, 1:    write_reg(REG_LATENCY, 0);
                2:       write_reg(REG_LATENCY, CFG_DATA_W'($urandom_range(1, 300)));
                default: write_reg(REG_LATENCY, CFG_DATA_W'($urandom_range(1, 48)));
            endcase
            write_reg(REG_HOLD_EXTRA, CFG_DATA_W'($urandom_range(0, 40)));
            start = frames_sent;
            // random levels start fades too; a fade may run across phases
            while (frames_sent - start < 170) begin
                if ($urandom_range(5) == 0) begin
                    start_reload();
                end else begin
                    repeat ($urandom_range(5, 30))
                        send_frame(make_frame(1'($urandom_range(1)),
                                              1'($urandom_range(1))));
                end
            end
            drain();
        end
    endtask

    initial begin
        foreach (dly_l[k]) begin
            dly_l[k] = '0;
            dly_r[k] = '0;
        end
        dly_pos        = 0;
        phase          = FADE_IDLE;
        fade_cnt       = 0;
        hold_cnt       = 0;
        level_prev     = 1'b0;
        cfg_latency    = 0;
        cfg_hold       = 0;
        error_count    = 0;
        beats_checked  = 0;
        frames_sent    = 0;
        reload_lvl     = 1'b0;
        set_idling(0, 0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_short_delay();
        test_reload_fade();
        test_latency_change();
        test_extremes();
        test_random();

        drain();
        repeat (8) @(posedge i_clk);
        if (faded_frames.size() != 0)
            report_mismatch("beats never delivered", SAMPLE_W'(faded_frames.size()), '0);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bdrf_pkg.sv
sv/bdrf_ctrl.sv
sv/bdrf_lane.sv
sv/bdrf_merge.sv
sv/bypass_delay_with_reload_fade.sv
sv/bdrf_chk.sv
verif/bypass_delay_with_reload_fade_test.sv
